FILE: src/trace_frame_encoder_top_macros.svh
// ----------------------------------------------------------------------------
// Trace frame encoder assertion macros
// Clocked, reset-qualified property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef TRACE_FRAME_ENCODER_TOP_MACROS_SVH
`define TRACE_FRAME_ENCODER_TOP_MACROS_SVH

// same-cycle implication
`define TFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tfe_pkg.sv
// ----------------------------------------------------------------------------
// Trace frame encoder package
// Shared types and constants for the front end, queue and back end.
// ----------------------------------------------------------------------------
package tfe_pkg;

    localparam int WORD_W    = 32;
    localparam int ADDR_W    = 10;
    localparam int CODE_W    = 3;
    localparam int ARG_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE    = 1'b1;

    typedef enum logic {
        OP_RESTART = 1'b0,
        OP_EVENT   = 1'b1
    } tfe_op_t;

    // one queued frame: first word, optional timestamp word
    typedef struct packed {
        logic              ext;
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] stamp;
        logic [ADDR_W-1:0] addr;
    } tfe_cmd_t;

endpackage

FILE: src/trace_frame_encoder_top.sv
// An accepted item is written into a queue entry register, then loaded into
// the back-end output register before its first word appears on m_*.
// One output word per cycle while m_ready is high; restart and normal frames
// give one word, extended frames two. Dropped events are accepted, no word.
// Synchronous active-low reset clears config, write position, queue and output.
// ----------------------------------------------------------------------------
// Trace frame encoder top level
// Front end, two-entry command queue and word-emitting back end.
// ----------------------------------------------------------------------------
module trace_frame_encoder_top #(
    parameter int BUFFER_WORDS  = 1024,
    parameter int REL_DELTA_MAX = 1048575
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tfe_pkg::WORD_W-1:0]       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [tfe_pkg::CODE_W-1:0]       s_event_code,
    input  logic [tfe_pkg::ARG_W-1:0]        s_event_arg,
    input  logic [tfe_pkg::WORD_W-1:0]       s_timestamp,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tfe_pkg::WORD_W-1:0]       m_trace_word,
    output logic [tfe_pkg::ADDR_W-1:0]       m_word_addr,
    output logic                             m_last
);
    import tfe_pkg::*;

    logic     push_valid, push_ready;
    tfe_cmd_t push_cmd;
    logic     pop_valid, pop_ready;
    tfe_cmd_t pop_cmd;

    tfe_front #(
        .BUFFER_WORDS  (BUFFER_WORDS),
        .REL_DELTA_MAX (REL_DELTA_MAX)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_event_code (s_event_code),
        .s_event_arg  (s_event_arg),
        .s_timestamp  (s_timestamp),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    tfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    tfe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_trace_word (m_trace_word),
        .m_word_addr  (m_word_addr),
        .m_last       (m_last)
    );

endmodule

FILE: src/tfe_front.sv
// ----------------------------------------------------------------------------
// Trace frame encoder front end
// Holds configuration and trace state, classifies each item and builds the
// frame command that is queued for the back end.
// ----------------------------------------------------------------------------
module tfe_front #(
    parameter int BUFFER_WORDS  = 1024,
    parameter int REL_DELTA_MAX = 1048575
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tfe_pkg::WORD_W-1:0]       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [tfe_pkg::CODE_W-1:0]       s_event_code,
    input  logic [tfe_pkg::ARG_W-1:0]        s_event_arg,
    input  logic [tfe_pkg::WORD_W-1:0]       s_timestamp,
    output logic                             push_valid,
    input  logic                             push_ready,
    output tfe_pkg::tfe_cmd_t                push_cmd
);
    import tfe_pkg::*;

    localparam int POS_W = $clog2(BUFFER_WORDS + 1);
    localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(BUFFER_WORDS - 1);
    localparam logic [WORD_W-1:0] DELTA_LIMIT = WORD_W'(REL_DELTA_MAX);

    logic              trace_enable_reg, trace_enable_next;
    logic [WORD_W-1:0] tick_rate_reg, tick_rate_next;
    logic [POS_W-1:0]  write_pos_reg, write_pos_next;
    logic [WORD_W-1:0] prev_stamp_reg, prev_stamp_next;
    logic              prev_valid_reg, prev_valid_next;

    logic              accept;
    logic              is_restart;
    logic              record;
    logic              near;
    logic [WORD_W-1:0] diff;
    logic [31:0]       pos_ext;

    assign cfg_ready  = 1'b1;
    assign s_ready    = push_ready;
    assign accept     = s_valid && push_ready;
    assign is_restart = (s_op == OP_RESTART);
    assign record     = !is_restart && trace_enable_reg && (write_pos_reg < LAST_POS);
    assign diff       = s_timestamp - prev_stamp_reg;
    assign near       = prev_valid_reg && (diff <= DELTA_LIMIT);
    assign pos_ext    = 32'(write_pos_reg);
    assign push_valid = accept && (is_restart || record);

    always_comb begin
        push_cmd.stamp = s_timestamp;
        if (is_restart) begin
            push_cmd.ext   = 1'b0;
            push_cmd.word0 = tick_rate_reg;
            push_cmd.addr  = '0;
        end else if (near) begin
            push_cmd.ext   = 1'b0;
            push_cmd.word0 = {1'b0, s_event_code, diff[19:16], s_event_arg, diff[15:0]};
            push_cmd.addr  = pos_ext[ADDR_W-1:0];
        end else begin
            push_cmd.ext   = 1'b1;
            push_cmd.word0 = {1'b1, s_event_code, 4'b0000, s_event_arg, 16'h0000};
            push_cmd.addr  = pos_ext[ADDR_W-1:0];
        end
    end

    always_comb begin
        trace_enable_next = trace_enable_reg;
        tick_rate_next    = tick_rate_reg;
        write_pos_next    = write_pos_reg;
        prev_stamp_next   = prev_stamp_reg;
        prev_valid_next   = prev_valid_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_TRACE_ENABLE: trace_enable_next = cfg_data[0];
                REG_TICK_RATE:    tick_rate_next    = cfg_data;
                default: ;
            endcase
        end
        if (accept) begin
            if (is_restart) begin
                write_pos_next  = POS_W'(1);
                prev_stamp_next = '0;
                prev_valid_next = 1'b0;
            end else if (record) begin
                write_pos_next  = write_pos_reg + (near ? POS_W'(1) : POS_W'(2));
                prev_stamp_next = s_timestamp;
                prev_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trace_enable_reg <= 1'b0;
            tick_rate_reg    <= '0;
            write_pos_reg    <= '0;
            prev_stamp_reg   <= '0;
            prev_valid_reg   <= 1'b0;
        end else begin
            trace_enable_reg <= trace_enable_next;
            tick_rate_reg    <= tick_rate_next;
            write_pos_reg    <= write_pos_next;
            prev_stamp_reg   <= prev_stamp_next;
            prev_valid_reg   <= prev_valid_next;
        end
    end

endmodule

FILE: src/tfe_queue.sv
// ----------------------------------------------------------------------------
// Trace frame encoder command queue
// Two-entry register queue between front and back end.
// ----------------------------------------------------------------------------
module tfe_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  tfe_pkg::tfe_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop_ready,
    output tfe_pkg::tfe_cmd_t pop_cmd
);
    import tfe_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfe_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/tfe_back.sv
// ----------------------------------------------------------------------------
// Trace frame encoder back end
// Pops commands into the output register, one word per cycle while m_ready is
// high; an extended frame holds its timestamp word till the first word leaves.
// ----------------------------------------------------------------------------
module tfe_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  tfe_pkg::tfe_cmd_t           pop_cmd,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tfe_pkg::WORD_W-1:0]  m_trace_word,
    output logic [tfe_pkg::ADDR_W-1:0]  m_word_addr,
    output logic                        m_last
);
    import tfe_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic              out_last_reg, out_last_next;
    logic              pend_reg, pend_next;
    logic [WORD_W-1:0] pend_stamp_reg, pend_stamp_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              load;

    assign load      = !out_valid_reg || m_ready;
    assign pop_ready = load && !pend_reg;

    assign m_valid      = out_valid_reg;
    assign m_trace_word = out_word_reg;
    assign m_word_addr  = out_addr_reg;
    assign m_last       = out_last_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_addr_next   = out_addr_reg;
        out_last_next   = out_last_reg;
        pend_next       = pend_reg;
        pend_stamp_next = pend_stamp_reg;
        pend_addr_next  = pend_addr_reg;
        if (load) begin
            if (pend_reg) begin
                out_valid_next = 1'b1;
                out_word_next  = pend_stamp_reg;
                out_addr_next  = pend_addr_reg;
                out_last_next  = 1'b1;
                pend_next      = 1'b0;
            end else if (pop_valid) begin
                out_valid_next  = 1'b1;
                out_word_next   = pop_cmd.word0;
                out_addr_next   = pop_cmd.addr;
                out_last_next   = !pop_cmd.ext;
                pend_next       = pop_cmd.ext;
                pend_stamp_next = pop_cmd.stamp;
                pend_addr_next  = pop_cmd.addr + ADDR_W'(1);
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg   <= out_word_next;
        out_addr_reg   <= out_addr_next;
        out_last_reg   <= out_last_next;
        pend_stamp_reg <= pend_stamp_next;
        pend_addr_reg  <= pend_addr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

endmodule

FILE: src/tfe_checker.sv
// ----------------------------------------------------------------------------
// Trace frame encoder port checker
// Output-side checks, bound onto the top level.
// ----------------------------------------------------------------------------
`include "trace_frame_encoder_top_macros.svh"

module tfe_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [tfe_pkg::WORD_W-1:0]       m_trace_word,
    input logic [tfe_pkg::ADDR_W-1:0]       m_word_addr,
    input logic                             m_last
);
    import tfe_pkg::*;

    `TFE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_trace_word) && $stable(m_word_addr) && $stable(m_last), "output item changed while stalled")
    `TFE_ASSERT_NOW(a_first_word_ext, m_valid && !m_last, m_trace_word[31], "non-final word is not an extended frame header")
    `TFE_ASSERT_NEXT(a_second_word, m_valid && m_ready && !m_last, m_valid && m_last, "timestamp word did not follow extended header")
    `TFE_ASSERT_NEXT(a_second_addr, m_valid && m_ready && !m_last, m_word_addr == ADDR_W'($past(m_word_addr) + ADDR_W'(1)), "timestamp word address not consecutive")

endmodule

bind trace_frame_encoder_top tfe_checker u_tfe_checker (.*);
